// ===== src/sidta_pkg.sv =====
// ----------------------------------------------------------------------------
// sidta_pkg
// Shared constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sidta_pkg;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Binary bits shifted into the BCD register per pipeline stage
  localparam int STEP_BITS = 4;

  // Digits of 5 or more get 3 added before each shift
  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

endpackage

// ===== src/sidta_serializer.sv =====
// ----------------------------------------------------------------------------
// sidta_serializer
// Emits one number's text one character per cycle: optional sign, then the
// digits from the top nonzero digit down to the units digit.
// ----------------------------------------------------------------------------
module sidta_serializer #(
  parameter int NUM_DIGITS = 10,
  parameter int DIGIT_IDX_W = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load_valid,
  input  logic                      load_neg,
  input  logic [4*NUM_DIGITS-1:0]   load_digits,
  input  logic [DIGIT_IDX_W-1:0]    load_top,
  output logic                      ready,
  output logic                      strobe,
  output logic [7:0]                char_code,
  output logic                      last_char
);

  logic                      active;
  logic                      neg_pending;
  logic [4*NUM_DIGITS-1:0]   digits;
  logic [DIGIT_IDX_W-1:0]    ptr;
  logic [3:0]                cur_digit;
  logic                      at_units;

  assign cur_digit = digits[{ptr, 2'b00} +: 4];
  assign at_units  = (ptr == '0);

  // free when idle or when the final character goes out this cycle
  assign ready = !active || (!neg_pending && at_units);

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      neg_pending <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      strobe <= active;
      if (active) begin
        if (neg_pending) begin
          char_code   <= sidta_pkg::CHAR_MINUS;
          last_char   <= 1'b0;
          neg_pending <= 1'b0;
        end else begin
          char_code <= sidta_pkg::CHAR_ZERO + {4'b0000, cur_digit};
          last_char <= at_units;
          if (!at_units) begin
            ptr <= ptr - DIGIT_IDX_W'(1);
          end
        end
      end
      if (ready) begin
        active <= load_valid;
        if (load_valid) begin
          digits      <= load_digits;
          ptr         <= load_top;
          neg_pending <= load_neg;
        end
      end
    end
  end

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Renders a two's-complement integer as decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge where start is high and busy is low;
//   value is sampled at that edge. Each character of the text then appears on
//   char_code for exactly one cycle with strobe high; last_char marks the
//   final character. Negative values start with '-', digits follow most
//   significant first with no leading zeros, zero gives "0".
//   Pipeline: one input stage (magnitude), ceil(VALUE_WIDTH/4) shift-add-3
//   stages of up to four bits each, one leading-zero scan stage, then the
//   character serializer and its output register.
//   Throughput: one character per cycle, and a number has 1 to 11 characters
//   at 32 bits; the serializer sets this rate.
//   Requests may be issued back to back; busy rises while the pipeline is
//   backed up behind the serializer.
//   The receiver cannot stall: strobe is never held off.
//   Reset clears all valid bits and drops any text in flight.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          strobe,
  output logic [7:0]                    char_code,
  output logic                          last_char
);

  localparam int NUM_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int STEP        = sidta_pkg::STEP_BITS;
  localparam int NUM_STEPS   = (VALUE_WIDTH + STEP - 1) / STEP;
  localparam int SCAN_ST     = NUM_STEPS + 1;

  logic                   valid [0:SCAN_ST];
  logic                   free  [0:SCAN_ST+1];
  logic                   neg   [0:NUM_STEPS];
  logic [VALUE_WIDTH-1:0] bin   [0:NUM_STEPS];
  logic [BCD_W-1:0]       bcd   [1:NUM_STEPS];

  logic [VALUE_WIDTH-1:0] mag_in;
  logic                   ser_ready;

  logic [BCD_W-1:0]       scan_digits;
  logic                   scan_neg;
  logic [DIGIT_IDX_W-1:0] scan_top;
  logic [DIGIT_IDX_W-1:0] top_next;

  // a stage can take new data when empty or when its content moves on
  always_comb begin
    free[SCAN_ST+1] = ser_ready;
    for (int i = SCAN_ST; i >= 0; i--) begin
      free[i] = !valid[i] || free[i+1];
    end
  end

  assign busy   = !free[0];
  assign mag_in = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (free[0]) begin
      valid[0] <= start;
    end
    if (free[0] && start) begin
      bin[0] <= mag_in;
      neg[0] <= value[VALUE_WIDTH-1];
    end
  end

  // shift-add-3 stages
  for (genvar s = 1; s <= NUM_STEPS; s++) begin : g_dabble
    localparam int LO  = (s - 1) * STEP;
    localparam int CNT = (VALUE_WIDTH - LO < STEP) ? (VALUE_WIDTH - LO) : STEP;

    logic [BCD_W-1:0]       bcd_in;
    logic [BCD_W-1:0]       bcd_step;
    logic [VALUE_WIDTH-1:0] bin_step;

    if (s == 1) begin : g_first
      assign bcd_in = '0;
    end else begin : g_rest
      assign bcd_in = bcd[s-1];
    end

    always_comb begin
      bcd_step = bcd_in;
      bin_step = bin[s-1];
      for (int k = 0; k < CNT; k++) begin
        for (int j = 0; j < NUM_DIGITS; j++) begin
          if (bcd_step[4*j +: 4] >= sidta_pkg::BCD_ADJ_LIMIT) begin
            bcd_step[4*j +: 4] = bcd_step[4*j +: 4] + sidta_pkg::BCD_ADJ_ADD;
          end
        end
        bcd_step = {bcd_step[BCD_W-2:0], bin_step[VALUE_WIDTH-1]};
        bin_step = {bin_step[VALUE_WIDTH-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (free[s]) begin
        valid[s] <= valid[s-1];
      end
      if (free[s] && valid[s-1]) begin
        bcd[s] <= bcd_step;
        bin[s] <= bin_step;
        neg[s] <= neg[s-1];
      end
    end
  end

  // find the most significant nonzero digit; zero keeps the units digit
  always_comb begin
    top_next = '0;
    for (int j = 1; j < NUM_DIGITS; j++) begin
      if (bcd[NUM_STEPS][4*j +: 4] != 4'd0) begin
        top_next = DIGIT_IDX_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[SCAN_ST] <= 1'b0;
    end else if (free[SCAN_ST]) begin
      valid[SCAN_ST] <= valid[NUM_STEPS];
    end
    if (free[SCAN_ST] && valid[NUM_STEPS]) begin
      scan_digits <= bcd[NUM_STEPS];
      scan_neg    <= neg[NUM_STEPS];
      scan_top    <= top_next;
    end
  end

  sidta_serializer #(
    .NUM_DIGITS  (NUM_DIGITS),
    .DIGIT_IDX_W (DIGIT_IDX_W)
  ) u_serializer (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (valid[SCAN_ST]),
    .load_neg    (scan_neg),
    .load_digits (scan_digits),
    .load_top    (scan_top),
    .ready       (ser_ready),
    .strobe      (strobe),
    .char_code   (char_code),
    .last_char   (last_char)
  );

endmodule
